// File: rtl/core/phfc_pkg.sv
package phfc_pkg;

    // table geometry, must be a power of two
    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    localparam int KEY_W      = 64;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int COLL_W     = 32;
    localparam int SLOT_OUT_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COLL_W-1:0]  COLL_MAX  = '1;
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        OUTCOME_NEW       = 2'd0,
        OUTCOME_HIT       = 2'd1,
        OUTCOME_COLLISION = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } t_state;

    // one table entry, a count of zero marks it empty
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_slot;

endpackage

// File: rtl/core/phfc_if.sv
interface phfc_in_if;
    import phfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] key_low;
    logic [WORD_W-1:0] key_high;

    modport source (output valid, output key_low, output key_high, input ready);
    modport sink   (input valid, input key_low, input key_high, output ready);
endinterface

interface phfc_out_if;
    import phfc_pkg::*;

    logic                  valid;
    logic                  ready;
    t_outcome              outcome;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [COUNT_W-1:0]    occurrence_count;
    logic [COLL_W-1:0]     collision_total;

    modport source (output valid, output outcome, output slot_index,
                    output occurrence_count, output collision_total, input ready);
    modport sink   (input valid, input outcome, input slot_index,
                    input occurrence_count, input collision_total, output ready);
endinterface

// File: rtl/core/probing_hash_frequency_counter_unit.sv
// channel   dir   handshake      word
// i_in      in    valid/ready    key_low, key_high
// o_out     out   valid/ready    outcome, slot_index, occurrence_count, collision_total
//
// after reset a clearing pass writes every slot to zero, one slot a cycle,
// with i_in.ready low.
// an item is accepted, then probed slot by slot through the read of the slot memory,
// registered, reused once per probe step.
// the result sits in an output register; a new word is taken while it waits, and
// the probe only stalls at its final step if that register is still full.
module probing_hash_frequency_counter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    phfc_in_if.sink              i_in,
    phfc_out_if.source           o_out
);
    import phfc_pkg::*;

    t_slot r_mem [TABLE_ENTRIES];

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [KEY_W-1:0]    r_key, n_key;
    t_slot               r_rd;
    logic [COLL_W-1:0]   r_coll, n_coll;

    logic                  r_out_valid, n_out_valid;
    t_outcome              r_outcome, n_outcome;
    logic [SLOT_OUT_W-1:0] r_slot, n_slot;
    logic [COUNT_W-1:0]    r_cnt, n_cnt;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot             wr_data;
    logic              out_free;
    logic              in_ready;
    logic [COUNT_W-1:0] cnt_inc;

    assign out_free = !r_out_valid || o_out.ready;
    assign cnt_inc  = (r_rd.count == COUNT_MAX) ? r_rd.count : r_rd.count + COUNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_clr       = r_clr;
        n_key       = r_key;
        n_coll      = r_coll;
        n_out_valid = r_out_valid && !o_out.ready;
        n_outcome   = r_outcome;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_pos;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = '0;

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    rd_en   = 1'b1;
                    rd_addr = i_in.key_low[SLOT_W-1:0];
                    n_pos   = i_in.key_low[SLOT_W-1:0];
                    n_key   = {i_in.key_high, i_in.key_low};
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_rd.count == '0) begin
                    if (out_free) begin
                        wr_en         = 1'b1;
                        wr_data.key   = r_key;
                        wr_data.count = COUNT_W'(1);
                        n_out_valid   = 1'b1;
                        n_outcome     = OUTCOME_NEW;
                        n_slot        = SLOT_OUT_W'(r_pos);
                        n_cnt         = COUNT_W'(1);
                        n_state       = ST_IDLE;
                    end
                end else if (r_rd.key == r_key) begin
                    if (out_free) begin
                        wr_en         = 1'b1;
                        wr_data.key   = r_key;
                        wr_data.count = cnt_inc;
                        n_out_valid   = 1'b1;
                        n_outcome     = OUTCOME_HIT;
                        n_slot        = SLOT_OUT_W'(r_pos);
                        n_cnt         = cnt_inc;
                        n_state       = ST_IDLE;
                    end
                end else if (r_rd.key[SLOT_W-1:0] != r_key[SLOT_W-1:0] ||
                             r_pos == SLOT_LAST) begin
                    // foreign home or end of table, key is dropped
                    if (out_free) begin
                        if (r_coll != COLL_MAX) begin
                            n_coll = r_coll + COLL_W'(1);
                        end
                        n_out_valid = 1'b1;
                        n_outcome   = OUTCOME_COLLISION;
                        n_slot      = SLOT_OUT_W'(r_pos);
                        n_cnt       = '0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    // same home, step to the next slot
                    n_pos   = r_pos + SLOT_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_pos + SLOT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_coll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_coll      <= n_coll;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign i_in.ready             = in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.outcome          = r_outcome;
    assign o_out.slot_index       = r_slot;
    assign o_out.occurrence_count = r_cnt;
    assign o_out.collision_total  = r_coll;

`ifndef SYNTHESIS
    // a new entry always starts at one, a collision never reports a count
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_outcome == OUTCOME_NEW) |-> (r_cnt == COUNT_W'(1)))
        else $error("new entry word with count other than one");

    a_coll_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_outcome == OUTCOME_COLLISION) |-> (r_cnt == '0))
        else $error("collision word with nonzero count");

    // probe never walks below its home slot
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_pos >= r_key[SLOT_W-1:0]))
        else $error("probe position below home slot");

    // collision total only steps by one, and only with a collision word loaded
    a_coll_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE && n_coll != r_coll) |=>
        (r_out_valid && r_outcome == OUTCOME_COLLISION))
        else $error("collision total moved without a collision word");
`endif

endmodule
